@@ hdl/msd_pkg.sv @@
package msd_pkg;

   localparam int MAX_ELEMENTS = 7;
   localparam int COUNT_W      = 3;
   localparam int PATTERN_W    = 7;
   localparam int CODE_COUNT   = 43;

   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_DASH     = 8'h2D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_message;
   } req_word_type;

   typedef struct packed {
      logic [7:0] decoded_char;
      logic       recognized;
   } rsp_word_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   count;
      logic [PATTERN_W-1:0] pattern;
      logic                 poisoned;
   } word_state_type;

   // Bit i of a pattern is element i of the code, one for a dash.
   typedef struct packed {
      logic [COUNT_W-1:0]   len;
      logic [PATTERN_W-1:0] pattern;
      logic [7:0]           code;
   } code_entry_type;

   localparam code_entry_type CODE_TABLE [CODE_COUNT] = '{
      '{3'd5, 7'b0011111, 8'h30},
      '{3'd5, 7'b0011110, 8'h31},
      '{3'd5, 7'b0011100, 8'h32},
      '{3'd5, 7'b0011000, 8'h33},
      '{3'd5, 7'b0010000, 8'h34},
      '{3'd5, 7'b0000000, 8'h35},
      '{3'd5, 7'b0000001, 8'h36},
      '{3'd5, 7'b0000011, 8'h37},
      '{3'd5, 7'b0000111, 8'h38},
      '{3'd5, 7'b0001111, 8'h39},
      '{3'd6, 7'b0000111, 8'h3A},
      '{3'd6, 7'b0101010, 8'h2E},
      '{3'd6, 7'b0110011, 8'h2C},
      '{3'd5, 7'b0010001, 8'h3D},
      '{3'd5, 7'b0001100, 8'h21},
      '{3'd6, 7'b0001100, 8'h3F},
      '{3'd6, 7'b0010010, 8'h22},
      '{3'd2, 7'b0000010, 8'h41},
      '{3'd4, 7'b0000001, 8'h42},
      '{3'd4, 7'b0000101, 8'h43},
      '{3'd3, 7'b0000001, 8'h44},
      '{3'd1, 7'b0000000, 8'h45},
      '{3'd4, 7'b0000100, 8'h46},
      '{3'd3, 7'b0000011, 8'h47},
      '{3'd4, 7'b0000000, 8'h48},
      '{3'd2, 7'b0000000, 8'h49},
      '{3'd4, 7'b0001110, 8'h4A},
      '{3'd3, 7'b0000101, 8'h4B},
      '{3'd4, 7'b0000010, 8'h4C},
      '{3'd2, 7'b0000011, 8'h4D},
      '{3'd2, 7'b0000001, 8'h4E},
      '{3'd3, 7'b0000111, 8'h4F},
      '{3'd4, 7'b0000110, 8'h50},
      '{3'd4, 7'b0001011, 8'h51},
      '{3'd3, 7'b0000010, 8'h52},
      '{3'd3, 7'b0000000, 8'h53},
      '{3'd1, 7'b0000001, 8'h54},
      '{3'd3, 7'b0000100, 8'h55},
      '{3'd4, 7'b0001000, 8'h56},
      '{3'd3, 7'b0000110, 8'h57},
      '{3'd4, 7'b0001001, 8'h58},
      '{3'd4, 7'b0001101, 8'h59},
      '{3'd4, 7'b0000011, 8'h5A}
   };

endpackage

@@ hdl/msd_accum.sv @@
module msd_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  msd_pkg::req_word_type  word,
   output msd_pkg::word_state_type state
);
   import msd_pkg::*;

   word_state_type state_ff;
   word_state_type state_in;
   logic           is_dot;
   logic           is_dash;
   logic           is_space;

   assign is_dot   = (word.text_char == CHAR_DOT);
   assign is_dash  = (word.text_char == CHAR_DASH);
   assign is_space = (word.text_char == CHAR_SPACE);

   always_comb begin
      state_in = state_ff;
      if (step) begin
         priority if (word.end_of_message || is_space) begin
            state_in = '0;
         end else if (is_dot || is_dash) begin
            if (state_ff.count >= COUNT_W'(MAX_ELEMENTS)) begin
               state_in.poisoned = 1'b1;
            end else begin
               state_in.pattern = state_ff.pattern
                                | (PATTERN_W'(is_dash) << state_ff.count);
               state_in.count   = state_ff.count + COUNT_W'(1);
            end
         end else begin
            state_in.poisoned = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

@@ hdl/msd_lookup.sv @@
module msd_lookup (
   input  msd_pkg::word_state_type state,
   output msd_pkg::rsp_word_type   result
);
   import msd_pkg::*;

   logic       hit;
   logic [7:0] code;

   always_comb begin
      hit  = 1'b0;
      code = CHAR_QUESTION;
      for (int k = CODE_COUNT - 1; k >= 0; k--) begin
         if (CODE_TABLE[k].len == state.count && CODE_TABLE[k].pattern == state.pattern) begin
            hit  = 1'b1;
            code = CODE_TABLE[k].code;
         end
      end
   end

   always_comb begin
      priority if (state.poisoned) begin
         result.decoded_char = CHAR_QUESTION;
         result.recognized   = 1'b0;
      end else if (state.count == '0) begin
         result.decoded_char = CHAR_SPACE;
         result.recognized   = 1'b1;
      end else begin
         result.decoded_char = code;
         result.recognized   = hit;
      end
   end

endmodule

@@ hdl/morse_stream_decoder.sv @@
// Morse text decoder. Each input word carries one ASCII character of Morse
// text: dots and dashes build up a code of up to seven elements, and a space
// closes it and returns one output word with the decoded digit, letter or
// punctuation mark, a space for an empty code, or a question mark with
// recognized low when the code is unknown, too long or held any other
// character. End of message drops an unfinished code and returns nothing.
// A new input word is accepted every cycle unless the input is stalled; a
// character passes one input register and one output register, so a decoded
// character is loaded into the output register as the space that closes it
// leaves the input register. Only a stalled output word holding back a space
// stalls the input.
module morse_stream_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  msd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output msd_pkg::rsp_word_type rsp_word
);
   import msd_pkg::*;

   logic           s1_valid_ff;
   req_word_type   s1_word_ff;
   logic           r_valid_ff;
   rsp_word_type   r_word_ff;
   logic           s1_emits;
   logic           s1_go;
   logic           out_blocked;
   word_state_type state;
   rsp_word_type   decoded;

   assign s1_emits    = !s1_word_ff.end_of_message && (s1_word_ff.text_char == CHAR_SPACE);
   assign out_blocked = r_valid_ff && rsp_stall;
   assign s1_go       = s1_valid_ff && !(s1_emits && out_blocked);
   assign req_stall   = s1_valid_ff && !s1_go;

   msd_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (s1_go),
      .word  (s1_word_ff),
      .state (state)
   );

   msd_lookup u_lookup (
      .state  (state),
      .result (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         r_valid_ff  <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_go && s1_emits) begin
            r_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            r_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_word_ff <= req_word;
      end
      if (s1_go && s1_emits) begin
         r_word_ff <= decoded;
      end
   end

   assign rsp_valid = r_valid_ff;
   assign rsp_word  = r_word_ff;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   import msd_pkg::*;

   class morse_text_checker;
      logic [7:0]   char_of_code [string];
      bit           codes_hit [string];
      string        known_codes [$];
      string        code_so_far;
      bit           word_broken;
      rsp_word_type pending_chars [$];
      int unsigned  errors;
      int unsigned  chars_seen;
      int unsigned  words_checked;
      int unsigned  fallbacks;
      int unsigned  message_ends;

      function void add_code(string pattern, logic [7:0] ch);
         char_of_code[pattern] = ch;
         known_codes.push_back(pattern);
      endfunction

      function new();
         add_code("-----", "0");   add_code(".----", "1");   add_code("..---", "2");
         add_code("...--", "3");   add_code("....-", "4");   add_code(".....", "5");
         add_code("-....", "6");   add_code("--...", "7");   add_code("---..", "8");
         add_code("----.", "9");   add_code("---...", ":");  add_code(".-.-.-", ".");
         add_code("--..--", ",");  add_code("-...-", "=");   add_code("..--.", "!");
         add_code("..--..", "?");  add_code(".-..-.", "\""); add_code(".-", "A");
         add_code("-...", "B");    add_code("-.-.", "C");    add_code("-..", "D");
         add_code(".", "E");       add_code("..-.", "F");    add_code("--.", "G");
         add_code("....", "H");    add_code("..", "I");      add_code(".---", "J");
         add_code("-.-", "K");     add_code(".-..", "L");    add_code("--", "M");
         add_code("-.", "N");      add_code("---", "O");     add_code(".--.", "P");
         add_code("--.-", "Q");    add_code(".-.", "R");     add_code("...", "S");
         add_code("-", "T");       add_code("..-", "U");     add_code("...-", "V");
         add_code(".--", "W");     add_code("-..-", "X");    add_code("-.--", "Y");
         add_code("--..", "Z");
         code_so_far = "";
      endfunction

      function void note_char(req_word_type w);
         rsp_word_type decoded;
         chars_seen++;
         if (w.end_of_message) begin
            message_ends++;
            code_so_far = "";
            word_broken = 1'b0;
            return;
         end
         case (w.text_char)
            CHAR_DOT, CHAR_DASH: begin
               if (code_so_far.len() >= MAX_ELEMENTS) begin
                  word_broken = 1'b1;
               end else if (w.text_char == CHAR_DASH) begin
                  code_so_far = {code_so_far, "-"};
               end else begin
                  code_so_far = {code_so_far, "."};
               end
            end
            CHAR_SPACE: begin
               if (word_broken) begin
                  decoded = '{decoded_char: CHAR_QUESTION, recognized: 1'b0};
               end else if (code_so_far.len() == 0) begin
                  decoded = '{decoded_char: CHAR_SPACE, recognized: 1'b1};
               end else if (char_of_code.exists(code_so_far)) begin
                  decoded = '{decoded_char: char_of_code[code_so_far], recognized: 1'b1};
                  codes_hit[code_so_far] = 1'b1;
               end else begin
                  decoded = '{decoded_char: CHAR_QUESTION, recognized: 1'b0};
               end
               pending_chars.push_back(decoded);
               code_so_far = "";
               word_broken = 1'b0;
            end
            default: begin
               word_broken = 1'b1;
            end
         endcase
      endfunction

      function void check_decoded(rsp_word_type got);
         rsp_word_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: decoded char %h recognized %b arrived with none pending",
                     $time, got.decoded_char, got.recognized);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         words_checked++;
         if (!want.recognized) fallbacks++;
         if (got.decoded_char !== want.decoded_char) begin
            $display("%0t: decoded_char expected %h, got %h",
                     $time, want.decoded_char, got.decoded_char);
            errors++;
         end
         if (got.recognized !== want.recognized) begin
            $display("%0t: recognized expected %b, got %b",
                     $time, want.recognized, got.recognized);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   morse_text_checker checker_q = new();
   int unsigned       sent_count;
   bit                tx_quiet;
   bit                rx_quiet;
   bit                long_hold;

   morse_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("morse_stream_decoder: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) checker_q.note_char(req_word);
         if (rsp_valid && !rsp_stall) checker_q.check_decoded(rsp_word);
      end
   end

   function automatic int unsigned pause_len(bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin : receiver
      int unsigned hold;
      bit          was_long;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         was_long = long_hold;
         hold = was_long ? 200 : pause_len(rx_quiet);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            if (was_long) long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with valid either
   // still high or lowered in an earlier step.
   task automatic send_char(input logic [7:0] ch, input logic eom);
      int unsigned gap;
      req_valid <= 1'b1;
      req_word <= '{text_char: ch, end_of_message: eom};
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
      gap = pause_len(tx_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   task automatic send_random_word();
      int unsigned kind;
      int unsigned n;
      int unsigned spot;
      string       pattern;
      kind = $urandom_range(0, 99);
      pattern = checker_q.known_codes[$urandom_range(0, checker_q.known_codes.size() - 1)];
      if (kind >= 88) begin
         n = $urandom_range(1, 3);
         repeat (n) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
         return;
      end
      if (kind >= 50 && kind < 70) begin
         pattern = "";
         n = $urandom_range(0, 8);
         repeat (n) begin
            if ($urandom_range(0, 1)) pattern = {pattern, "-"};
            else pattern = {pattern, "."};
         end
      end
      spot = (kind >= 70 && kind < 80) ? $urandom_range(0, pattern.len()) : 999;
      for (int i = 0; i <= pattern.len(); i++) begin
         if (i == spot) send_char(8'($urandom_range(0, 255)), 1'b0);
         if (i < pattern.len()) send_char(pattern[i], 1'b0);
      end
      if (kind >= 80) send_char(8'($urandom_range(0, 255)), 1'b1);
      else send_char(CHAR_SPACE, 1'b0);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (checker_q.pending_chars.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text(" ");
      send_char(8'hFF, 1'b0);
      send_text(" ");
      send_text("-");
      send_char(8'h00, 1'b1);
      send_text("..--.. ");
      send_text(".-.-.-. ");
      send_text("-------. ");

      while (sent_count < 400) send_random_word();
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      while (sent_count < 550) send_random_word();
      rx_quiet = 1'b0;
      long_hold = 1'b1;
      repeat (30) send_random_word();
      tx_quiet = 1'b0;
      wait_for_drain();
      while (sent_count < 1300) send_random_word();
      wait_for_drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d characters, %0d message ends; %0d words checked, %0d unrecognized.",
               checker_q.chars_seen, checker_q.message_ends, checker_q.words_checked,
               checker_q.fallbacks);
      $display("Table codes decoded: %0d of %0d.",
               checker_q.codes_hit.num(), checker_q.known_codes.size());
      if (checker_q.errors == 0) begin
         $display("morse_stream_decoder: match");
      end else begin
         $display("morse_stream_decoder: mismatch");
      end
      $finish;
   end

endmodule
